### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### hw/rtl/kcl_pkg.sv
package kcl_pkg;
	localparam logic [2:0] CMD_APPEND  = 3'd0;
	localparam logic [2:0] CMD_PREPEND = 3'd1;
	localparam logic [2:0] CMD_INSERT  = 3'd2;
	localparam logic [2:0] CMD_DELETE  = 3'd3;
	localparam logic [2:0] CMD_UPDATE  = 3'd4;
	localparam logic [2:0] CMD_DUMP    = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// walk kinds requested of the datapath
	localparam logic [1:0] WALK_KEY  = 2'd0;
	localparam logic [1:0] WALK_PRED = 2'd1;
	localparam logic [1:0] WALK_DUMP = 2'd2;

	// datapath commands
	typedef struct packed {
		logic       load;      // latch input transaction
		logic       walk_start;
		logic [1:0] walk_kind;
		logic       key_sel;   // 0 find_key, 1 new_key
		logic       step;      // advance walk by one slot
		logic       mem_rd;    // read slot at pointer
		logic       rd_found;  // read at the found slot instead of the pointer
		logic       find_tail; // predecessor walk targets the head
		logic       do_append;
		logic       do_prepend;
		logic       do_first;  // add into empty list
		logic       do_insert;
		logic       do_delete;
		logic       do_update;
		logic       save_anchor;
	} kcl_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic one;
		logic walk_done; // walk is at the final entry
		logic hit;       // current slot matches
		logic rd_ok;     // read data valid
	} kcl_stat_t;
endpackage

### hw/rtl/kcl_datapath.sv
module kcl_datapath
	import kcl_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kcl_cmd_t         cmd,
	output kcl_stat_t        stat,
	input  logic [31:0]      find_key,
	input  logic [31:0]      new_key,
	input  logic [31:0]      new_data,
	output logic [31:0]      rd_key,
	output logic [31:0]      rd_data
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// slot memories
	logic [31:0]   key_mem [CAPACITY];
	logic [31:0]   data_mem [CAPACITY];
	logic [AW-1:0] next_mem [CAPACITY];
	logic [CAPACITY-1:0] used_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic [31:0]   fkey_q, nkey_q, ndata_q;
	logic [AW-1:0] ptr_q, prev_q, anchor_q, found_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    kind_q;
	logic          sel_q, rd_ok_q;
	logic [AW-1:0] rd_next_q;
	logic [AW-1:0] rd_addr;
	logic          slot_hit;

	// lowest free slot
	logic [AW-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) free_slot = AW'(i);
		end
	end

	// registered memory read
	assign rd_addr = cmd.rd_found ? found_q : ptr_q;
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_key    <= key_mem[rd_addr];
			rd_data   <= data_mem[rd_addr];
			rd_next_q <= next_mem[rd_addr];
		end
	end

	// match on current slot for the walk kind
	logic [31:0] want;
	assign want = sel_q ? nkey_q : fkey_q;
	always_comb begin
		case (kind_q)
			WALK_KEY:  slot_hit = rd_ok_q && (rd_key == want);
			WALK_PRED: slot_hit = rd_ok_q && (rd_next_q == found_q);
			default:   slot_hit = 1'b0;
		endcase
	end
	assign stat.hit       = slot_hit;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q >= CW'(CAPACITY));
	assign stat.one       = (count_q == CW'(1));
	assign stat.walk_done = (({1'b0, idx_q} + {{CW{1'b0}}, 1'b1}) >= {1'b0, count_q});
	assign stat.rd_ok     = rd_ok_q;

	// slot writes
	always_ff @(posedge clk) begin
		if (cmd.do_first || cmd.do_append || cmd.do_prepend || cmd.do_insert) begin
			key_mem[free_slot]  <= nkey_q;
			data_mem[free_slot] <= ndata_q;
		end
		if (cmd.do_first) next_mem[free_slot] <= free_slot;
		if (cmd.do_append || cmd.do_prepend) begin
			next_mem[prev_q]    <= free_slot;
			next_mem[free_slot] <= head_q;
		end
		if (cmd.do_insert) begin
			next_mem[anchor_q]  <= free_slot;
			next_mem[free_slot] <= rd_next_q;
		end
		if (cmd.do_delete && !stat.one) next_mem[prev_q] <= rd_next_q;
		if (cmd.do_update) data_mem[found_q] <= ndata_q;
	end

	// control state of datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			head_q  <= '0;
			count_q <= '0;
			rd_ok_q <= 1'b0;
			idx_q   <= '0;
			ptr_q   <= '0;
			kind_q  <= WALK_KEY;
			sel_q   <= 1'b0;
		end else begin
			rd_ok_q <= cmd.mem_rd;
			if (cmd.walk_start) begin
				ptr_q  <= head_q;
				idx_q  <= '0;
				kind_q <= cmd.walk_kind;
				sel_q  <= cmd.key_sel;
			end else if (cmd.step) begin
				ptr_q <= rd_next_q;
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.do_first || cmd.do_append || cmd.do_prepend || cmd.do_insert) begin
				used_q[free_slot] <= 1'b1;
				count_q <= count_q + CW'(1);
			end
			if (cmd.do_first || cmd.do_prepend) head_q <= free_slot;
			if (cmd.do_delete) begin
				used_q[found_q] <= 1'b0;
				count_q <= count_q - CW'(1);
				if (stat.one) head_q <= '0;
				else if (found_q == head_q) head_q <= rd_next_q;
			end
		end
	end

	// operand and walk result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fkey_q  <= find_key;
			nkey_q  <= new_key;
			ndata_q <= new_data;
		end
		if (slot_hit && kind_q == WALK_KEY) found_q <= ptr_q;
		if (slot_hit && kind_q == WALK_PRED) prev_q <= ptr_q;
		if (cmd.find_tail) found_q <= head_q;
		if (cmd.save_anchor) anchor_q <= found_q;
	end
endmodule

### hw/rtl/kcl_ctrl.sv
module kcl_ctrl
	import kcl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  in_cmd,
	input  kcl_stat_t   stat,
	output kcl_cmd_t    cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  res_status,
	output logic        res_dump,
	output logic        res_last
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ORD   = 4'd1; // issue read
	localparam logic [3:0] S_CHK   = 4'd2; // compare read
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_PRED  = 4'd4;
	localparam logic [3:0] S_PCHK  = 4'd5;
	localparam logic [3:0] S_WRITE = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;
	localparam logic [3:0] S_DRD   = 4'd8;
	localparam logic [3:0] S_DOUT  = 4'd9;
	localparam logic [3:0] S_ARD   = 4'd10; // read next of found slot

	logic [3:0] state_q;
	logic [2:0] op_q, st_q;
	logic       phase_q; // insert: 0 anchor search, 1 new key search
	logic       hit_q;

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT) || (state_q == S_DOUT);
	assign res_dump = (state_q == S_DOUT);
	assign res_status = st_q;
	assign res_last = (state_q == S_OUT) || stat.walk_done;

	logic is_add;
	assign is_add = (op_q == CMD_APPEND) || (op_q == CMD_PREPEND);

	// commands per state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.walk_start = in_valid;
				cmd.walk_kind = (in_cmd == CMD_DUMP) ? WALK_DUMP : WALK_KEY;
				cmd.key_sel = (in_cmd == CMD_APPEND) || (in_cmd == CMD_PREPEND);
			end
			S_ORD, S_PRED, S_DRD: cmd.mem_rd = 1'b1;
			S_ARD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_found = 1'b1;
			end
			S_CHK: cmd.step = !stat.hit && !stat.walk_done;
			S_PCHK: cmd.step = !stat.hit;
			S_DECIDE: begin
				if (op_q == CMD_INSERT && !phase_q && hit_q) begin
					cmd.walk_start = 1'b1;
					cmd.walk_kind = WALK_KEY;
					cmd.key_sel = 1'b1;
					cmd.save_anchor = 1'b1;
				end else if (hit_q && op_q == CMD_DELETE && !stat.one) begin
					cmd.walk_start = 1'b1;
					cmd.walk_kind = WALK_PRED;
				end else if (!hit_q && is_add && !stat.full && !stat.empty) begin
					cmd.walk_start = 1'b1;
					cmd.walk_kind = WALK_PRED;
					cmd.find_tail = 1'b1;
				end
			end
			S_WRITE: begin
				case (op_q)
					CMD_APPEND:  begin
						cmd.do_first = stat.empty;
						cmd.do_append = !stat.empty;
					end
					CMD_PREPEND: begin
						cmd.do_first = stat.empty;
						cmd.do_prepend = !stat.empty;
					end
					CMD_INSERT: cmd.do_insert = 1'b1;
					CMD_DELETE: cmd.do_delete = 1'b1;
					CMD_UPDATE: cmd.do_update = 1'b1;
					default: ;
				endcase
			end
			S_DOUT: cmd.step = res_ready;
			default: ;
		endcase
	end

	// state sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= CMD_APPEND;
			st_q <= ST_OK;
			phase_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= in_cmd;
					phase_q <= 1'b0;
					hit_q <= 1'b0;
					st_q <= ST_OK;
					if (in_cmd == CMD_DUMP) begin
						if (stat.empty) begin
							st_q <= ST_EMPTY;
							state_q <= S_OUT;
						end else state_q <= S_DRD;
					end else if (in_cmd > CMD_DUMP) state_q <= S_IDLE;
					else if (stat.empty) state_q <= S_DECIDE;
					else state_q <= S_ORD;
				end
				S_ORD: state_q <= S_CHK;
				S_CHK: begin
					if (stat.hit) begin
						hit_q <= 1'b1;
						state_q <= S_DECIDE;
					end else if (stat.walk_done) begin
						state_q <= S_DECIDE;
					end else state_q <= S_ORD;
				end
				S_DECIDE: begin
					hit_q <= 1'b0;
					if (op_q == CMD_INSERT && !phase_q) begin
						if (!hit_q) begin
							st_q <= ST_NOTFOUND;
							state_q <= S_OUT;
						end else begin
							phase_q <= 1'b1;
							state_q <= S_ORD;
						end
					end else if (is_add || op_q == CMD_INSERT) begin
						if (hit_q) begin
							st_q <= ST_DUP;
							state_q <= S_OUT;
						end else if (stat.full) begin
							st_q <= ST_FULL;
							state_q <= S_OUT;
						end else if (op_q == CMD_INSERT) state_q <= S_ARD;
						else if (stat.empty) state_q <= S_WRITE;
						else state_q <= S_PRED;
					end else if (!hit_q) begin
						st_q <= ST_NOTFOUND;
						state_q <= S_OUT;
					end else if (op_q == CMD_DELETE) begin
						state_q <= stat.one ? S_ARD : S_PRED;
					end else state_q <= S_WRITE;
				end
				S_PRED: state_q <= S_PCHK;
				S_PCHK: begin
					if (stat.hit) state_q <= (op_q == CMD_DELETE) ? S_ARD : S_WRITE;
					else state_q <= S_PRED;
				end
				S_ARD: state_q <= S_WRITE;
				S_WRITE: state_q <= S_OUT;
				S_OUT: if (res_ready) state_q <= S_IDLE;
				S_DRD: state_q <= S_DOUT;
				S_DOUT: if (res_ready) state_q <= stat.walk_done ? S_IDLE : S_DRD;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/keyed_circular_list_engine.sv
// keyed circular list engine
// s_axis carries one command transaction: tdata holds command, find_key,
// new_key and new_data. m_axis returns results: tdata holds status,
// entry_key and entry_data; tlast marks the final result of a command.
// append, prepend, insert after, delete and update return one status;
// dump returns one result per entry in list order, or one empty status.
// commands six and seven are dropped without a result.
// one command is worked at a time; s_axis_tready is high only when idle.
// a key search visits the linked slots one by one, reading each slot and
// then comparing it; add into a non-empty list and delete from a list of
// two or more entries then walk again for the predecessor, and insert
// after searches twice. dump reads each entry and then offers it, moving
// to the next entry only once m_axis_tready takes it.
// reset empties the list at once; slot contents are left as they are.
// a stalled receiver holds the result and the engine waits in place.
`include "assert_macros.svh"
module keyed_circular_list_engine
	import kcl_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // command, find_key, new_key, new_data, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,  // status, entry_key, entry_data, pad
	output logic         m_axis_tlast
);
	kcl_cmd_t  cmd;
	kcl_stat_t stat;
	logic [31:0] rd_key, rd_data;
	logic [2:0]  res_status;
	logic        res_dump;

	kcl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tdata[2:0]), .stat(stat), .cmd(cmd),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_status(res_status), .res_dump(res_dump), .res_last(m_axis_tlast)
	);

	kcl_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.find_key(s_axis_tdata[34:3]), .new_key(s_axis_tdata[66:35]),
		.new_data(s_axis_tdata[98:67]), .rd_key(rd_key), .rd_data(rd_data)
	);

	// result packing
	assign m_axis_tdata = {5'd0, res_dump ? rd_data : 32'd0,
		res_dump ? rd_key : 32'd0, res_status};

	`ASSERT_IMPLIES(a_busy_no_take, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`ASSERT_NEXT(a_hold_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_IMPLIES(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] <= ST_EMPTY)
endmodule
